// File: hw/rtl/sliding_window_kth_smallest_macros.svh
// Assertion macros shared by the checker of the sliding-window rank filter.
// Depends on nothing; included by files that write concurrent assertions.
`ifndef SLIDING_WINDOW_KTH_SMALLEST_MACROS_SVH
`define SLIDING_WINDOW_KTH_SMALLEST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWKTH_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sliding window rank filter: assertion failed");

// Next-cycle implication, checked outside reset.
`define SWKTH_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sliding window rank filter: assertion failed");

`endif

// File: hw/rtl/swkth_pkg.sv
// Shared constants and types of the sliding-window rank filter.
// Used by the sorting cell and the top level; depends on nothing.
package swkth_pkg;

  // Configuration register widths and indexes.
  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANK          = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] WINDOW_LENGTH_RST = 5'd3;
  localparam logic [CFG_W-1:0] RANK_RST          = 5'd2;

  // Default sizes.
  localparam int DEF_MAX_WINDOW  = 16;
  localparam int DEF_SAMPLE_BITS = 32;

  // Operation broadcast to every cell in the same cycle.
  typedef struct packed {
    logic ins;  // a new sample enters the row
    logic del;  // the oldest sample leaves the row
  } cell_cmd_t;

  // Flags one cell shows to its neighbors.
  typedef struct packed {
    logic vld;  // the cell holds a sample
    logic le;   // the held sample is less than or equal to the new one
  } cell_nb_t;

endpackage

// File: hw/rtl/swkth_cell.sv
// One cell of the sorted row: holds a sample, its age and a valid flag.
// Depends on swkth_pkg; instantiated in a chain by the top level.
module swkth_cell #(
  parameter int W  = swkth_pkg::DEF_SAMPLE_BITS,
  parameter int AW = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swkth_pkg::cell_cmd_t cmd_i,
  input  logic signed [W-1:0]  sample_i,
  input  logic [AW-1:0]        oldest_i,
  input  logic                 shift_i,
  output logic                 shift_o,
  input  swkth_pkg::cell_nb_t  left_nb_i,
  input  logic signed [W-1:0]  left_val_i,
  input  logic [AW-1:0]        left_age_i,
  input  swkth_pkg::cell_nb_t  right_nb_i,
  input  logic signed [W-1:0]  right_val_i,
  input  logic [AW-1:0]        right_age_i,
  output swkth_pkg::cell_nb_t  nb_o,
  output logic signed [W-1:0]  val_o,
  output logic [AW-1:0]        age_o
);

  logic signed [W-1:0] val_q, val_d;
  logic [AW-1:0]       age_q, age_d;
  logic                vld_q, vld_d;
  logic                own_le, my_del, shift, below, prev_below, en;

  // Local compares: order against the new sample, and is this the oldest one.
  assign own_le = vld_q && (val_q <= sample_i);
  assign my_del = cmd_i.del && vld_q && (age_q == oldest_i);
  assign shift  = shift_i | my_del;

  // The row with the oldest removed is the old row shifted left from the hole on.
  // Below the insertion point the cell keeps that content; at it, it takes the
  // new sample; above it, it takes the content of its left neighbor.
  assign below      = !cmd_i.ins || (shift ? right_nb_i.le : own_le);
  assign prev_below = !cmd_i.ins || (shift_i ? own_le : left_nb_i.le);
  assign en         = cmd_i.ins | cmd_i.del;

  always_comb begin
    if (below) begin
      val_d = shift ? right_val_i : val_q;
      age_d = (shift ? right_age_i : age_q) + AW'(cmd_i.ins);
      vld_d = shift ? right_nb_i.vld : vld_q;
    end else if (prev_below) begin
      val_d = sample_i;
      age_d = '0;
      vld_d = 1'b1;
    end else begin
      val_d = shift_i ? val_q : left_val_i;
      age_d = (shift_i ? age_q : left_age_i) + AW'(1'b1);
      vld_d = shift_i ? vld_q : left_nb_i.vld;
    end
  end

  // Valid flag is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // Sample value and age are payload.
  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

  assign shift_o = shift;
  assign nb_o    = '{vld: vld_q, le: own_le};
  assign val_o   = val_q;
  assign age_o   = age_q;

endmodule

// File: hw/rtl/sliding_window_kth_smallest.sv
// Top level of the sliding-window rank filter: control, cell row, output word.
// Depends on swkth_pkg and swkth_cell.
//
// Usage:
// Samples arrive on sample_i with sample_valid_i; the block holds them off with
// sample_stall_o. Results leave on kth_value_o with kth_value_valid_o and are
// held off by kth_value_stall_i. Configuration words are written on the cfg
// channel (index 0: window length, index 1: rank), which is always ready;
// write them only while the block is idle.
// Once the window holds window_length samples, each accepted sample yields one
// word: the rank-th smallest sample of the window. Earlier samples yield none.
// A finished word waits in the row until the output register is free or its word is taken, then loads into it.
// Throughput is one sample per cycle while no trim runs and the output is not
// stalled, set by the row of sorting cells, which removes the oldest sample and
// inserts the new one in the same cycle. After the window length is lowered,
// the first sample waits while the extra samples leave the row, oldest first.
// Reset empties the window and loads window length 3 and rank 2.
// While the receiver stalls, the output word holds and one more finished word
// waits inside; then sample_stall_o rises until the output word is taken.
module sliding_window_kth_smallest #(
  parameter int MAX_WINDOW  = swkth_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = swkth_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                sample_valid_i,
  output logic                                sample_stall_o,
  output logic signed [SAMPLE_BITS-1:0]       kth_value_o,
  output logic                                kth_value_valid_o,
  input  logic                                kth_value_stall_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [swkth_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [swkth_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int LW = (CW > swkth_pkg::CFG_W) ? CW : swkth_pkg::CFG_W;

  logic [swkth_pkg::CFG_W-1:0] wlen_q, rank_q;
  logic [CW-1:0]               count_q, count_d, count_m1;
  logic                        drop_pend_q, res_pend_q;
  logic signed [SAMPLE_BITS-1:0] kth_q;
  logic                        kth_vld_q;

  logic [LW-1:0] wlen_x, max_x, len, rank_x, rnk, rnk_m1, cnt_x;
  logic          trim, load_out, acc, del, make_res;
  logic [AW-1:0] oldest, rsel;
  swkth_pkg::cell_cmd_t cmd;

  swkth_pkg::cell_nb_t         nb   [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] val [MAX_WINDOW];
  logic [AW-1:0]               age  [MAX_WINDOW];
  logic                        shift[MAX_WINDOW+1];

  // Configuration registers; the channel never pushes back.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= swkth_pkg::WINDOW_LENGTH_RST;
      rank_q <= swkth_pkg::RANK_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        swkth_pkg::REG_WINDOW_LENGTH: wlen_q <= cfg_data_i;
        swkth_pkg::REG_RANK:          rank_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective window length and rank after saturation.
  always_comb begin
    wlen_x = LW'(wlen_q);
    max_x  = LW'(MAX_WINDOW);
    rank_x = LW'(rank_q);
    cnt_x  = LW'(count_q);
    if (wlen_x == '0) begin
      len = LW'(1);
    end else if (wlen_x > max_x) begin
      len = max_x;
    end else begin
      len = wlen_x;
    end
    if (rank_x == '0) begin
      rnk = LW'(1);
    end else if (rank_x > len) begin
      rnk = len;
    end else begin
      rnk = rank_x;
    end
    rnk_m1 = rnk - LW'(1);
  end

  assign rsel = rnk_m1[AW-1:0];

  // Handshake and row operation. A lowered window length trims the row one oldest
  // sample per cycle, while no result is pending, before the next one is let in.
  assign trim           = (cnt_x > len) && !res_pend_q;
  assign load_out       = res_pend_q && (!kth_vld_q || !kth_value_stall_i);
  assign sample_stall_o = trim || (res_pend_q && !load_out);
  assign acc            = sample_valid_i && !sample_stall_o;
  assign del            = trim || (acc && (drop_pend_q || (cnt_x >= len)));
  assign cmd            = '{ins: acc, del: del};

  assign count_m1 = count_q - CW'(1);
  assign oldest   = count_m1[AW-1:0];
  assign count_d  = count_q - CW'(del) + CW'(acc);
  assign make_res = acc && (LW'(count_d) == len);

  // Fill count and pending flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      drop_pend_q <= 1'b0;
      res_pend_q  <= 1'b0;
      kth_vld_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) begin
        drop_pend_q <= make_res;
      end
      if (make_res) begin
        res_pend_q <= 1'b1;
      end else if (load_out) begin
        res_pend_q <= 1'b0;
      end
      if (load_out) begin
        kth_vld_q <= 1'b1;
      end else if (!kth_value_stall_i) begin
        kth_vld_q <= 1'b0;
      end
    end
  end

  // Output word: the selected cell of the sorted row.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      kth_q <= val[rsel];
    end
  end

  assign kth_value_o       = kth_q;
  assign kth_value_valid_o = kth_vld_q;

  // Row of sorting cells, smallest sample in cell 0.
  assign shift[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swkth_pkg::cell_nb_t           l_nb, r_nb;
    logic signed [SAMPLE_BITS-1:0] l_val, r_val;
    logic [AW-1:0]                 l_age, r_age;

    if (i == 0) begin : g_first
      assign l_nb  = '{vld: 1'b1, le: 1'b1};
      assign l_val = '0;
      assign l_age = '0;
    end else begin : g_inner_l
      assign l_nb  = nb[i-1];
      assign l_val = val[i-1];
      assign l_age = age[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_last
      assign r_nb  = '{vld: 1'b0, le: 1'b0};
      assign r_val = '0;
      assign r_age = '0;
    end else begin : g_inner_r
      assign r_nb  = nb[i+1];
      assign r_val = val[i+1];
      assign r_age = age[i+1];
    end

    swkth_cell #(
      .W  (SAMPLE_BITS),
      .AW (AW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .sample_i    (sample_i),
      .oldest_i    (oldest),
      .shift_i     (shift[i]),
      .shift_o     (shift[i+1]),
      .left_nb_i   (l_nb),
      .left_val_i  (l_val),
      .left_age_i  (l_age),
      .right_nb_i  (r_nb),
      .right_val_i (r_val),
      .right_age_i (r_age),
      .nb_o        (nb[i]),
      .val_o       (val[i]),
      .age_o       (age[i])
    );
  end

endmodule

// File: hw/rtl/swkth_checker.sv
// Port-level checker of the sliding-window rank filter, bound to the top level.
// Depends on sliding_window_kth_smallest_macros.svh and swkth_pkg.
`include "sliding_window_kth_smallest_macros.svh"

module swkth_checker #(
  parameter int SAMPLE_BITS = swkth_pkg::DEF_SAMPLE_BITS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            sample_valid_i,
  input logic                            sample_stall_o,
  input logic signed [SAMPLE_BITS-1:0]   kth_value_o,
  input logic                            kth_value_valid_o,
  input logic                            kth_value_stall_i
);

  logic in_acc;
  logic out_held;

  assign in_acc   = sample_valid_i && !sample_stall_o;
  assign out_held = kth_value_valid_o && kth_value_stall_i;

  // A stalled output word stays offered.
  `SWKTH_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, kth_value_valid_o)

  // A stalled output word keeps its value.
  `SWKTH_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_held, $stable(kth_value_o))

  // A fresh output word is first seen only after its sample was accepted and its word reached the output register.
  `SWKTH_ASSERT_IMP(a_out_latency, clk_i, rst_ni, $rose(kth_value_valid_o), $past(in_acc, 2))

  // The output register empties only after its word was taken.
  `SWKTH_ASSERT_IMP(a_out_drain, clk_i, rst_ni, $fell(kth_value_valid_o), $past(!kth_value_stall_i))

endmodule

bind sliding_window_kth_smallest swkth_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_swkth_checker (.*);

// File: bench/sliding_window_kth_smallest_test.sv
// Self-checking bench for the sliding-window rank filter: a directed table, then random
// phases under varied idling, checked word by word against the table or a window model.
// Depends on swkth_pkg and the sliding_window_kth_smallest top level.
module sliding_window_kth_smallest_test;

  localparam int WINDOW_MAX   = swkth_pkg::DEF_MAX_WINDOW;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 55;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 120;

  typedef enum logic {ROW_SAMPLE, ROW_CONFIG} row_kind_e;

  typedef logic [swkth_pkg::CFG_W-1:0] cfg_word_t;

  typedef struct {
    row_kind_e                         kind;
    logic [swkth_pkg::CFG_IDX_W-1:0]   reg_index;
    logic [swkth_pkg::CFG_W-1:0]       reg_value;
    logic signed [31:0]                value;
    bit                                typed;
    logic signed [31:0]                want;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic signed [31:0] sample = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [31:0] kth_value;
  logic kth_value_valid;
  logic kth_value_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [swkth_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [swkth_pkg::CFG_W-1:0] cfg_data = '0;

  // Model state: window contents in arrival order and the two registers.
  logic signed [31:0] window_q[$];
  logic [swkth_pkg::CFG_W-1:0] length_reg = swkth_pkg::WINDOW_LENGTH_RST;
  logic [swkth_pkg::CFG_W-1:0] rank_reg = swkth_pkg::RANK_RST;

  logic signed [31:0] pending_kth[$];
  table_row_t directed_rows[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;

  sliding_window_kth_smallest uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .sample_i         (sample),
    .sample_valid_i   (sample_valid),
    .sample_stall_o   (sample_stall),
    .kth_value_o      (kth_value),
    .kth_value_valid_o(kth_value_valid),
    .kth_value_stall_i(kth_value_stall),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Run limit, counted in clock cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Enter one sample into the window model; returns 1 when the window is full and
  // a word comes out, with the rank-th smallest value in kth.
  function automatic bit rank_filter_step(input logic signed [31:0] s,
                                          output logic signed [31:0] kth);
    int len;
    int r;
    int below;
    int at_or_below;
    len = int'(length_reg);
    if (len == 0) len = 1;
    else if (len > WINDOW_MAX) len = WINDOW_MAX;
    r = int'(rank_reg);
    if (r == 0) r = 1;
    if (r > len) r = len;
    kth = '0;
    // A shrunken window sheds its oldest samples before the new one enters.
    while (window_q.size() >= len) void'(window_q.pop_front());
    window_q.insert(window_q.size(), s);
    if (window_q.size() != len) return 1'b0;
    // The rank-th smallest is the value with fewer than r smaller entries and at
    // least r entries at or below it; duplicates count separately.
    foreach (window_q[i]) begin
      below = 0;
      at_or_below = 0;
      foreach (window_q[j]) begin
        if (window_q[j] < window_q[i]) below++;
        if (window_q[j] <= window_q[i]) at_or_below++;
      end
      if (below < r && r <= at_or_below) kth = window_q[i];
    end
    void'(window_q.pop_front());
    return 1'b1;
  endfunction

  // Mostly full-range values, with clusters of small ones for duplicates and extremes.
  function automatic logic signed [31:0] pick_sample();
    logic signed [31:0] v;
    case ($urandom_range(0, 19))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v = -32'sd1;
      3: v = 32'sd0;
      4, 5, 6, 7, 8: v = $signed($urandom_range(0, 6)) - 32'sd3;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_sample_row(input logic signed [31:0] v, input bit typed,
                                input logic signed [31:0] want);
    table_row_t row;
    row = '{ROW_SAMPLE, '0, '0, v, typed, want};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_config_row(input logic [swkth_pkg::CFG_IDX_W-1:0] idx,
                                input logic [swkth_pkg::CFG_W-1:0] val);
    table_row_t row;
    row = '{ROW_CONFIG, idx, val, '0, 1'b0, '0};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offer one sample after a random gap; the model runs at the accepting edge.
  task automatic offer_sample(input logic signed [31:0] v, input bit typed,
                              input logic signed [31:0] want);
    logic signed [31:0] kth;
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      sample_valid = 1'b0;
      @(negedge clk);
    end
    sample = v;
    sample_valid = 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (rank_filter_step(v, kth)) pending_kth.insert(pending_kth.size(), typed ? want : kth);
  endtask

  // Stop offering, wait for every expected word, then let in-flight samples settle.
  task automatic drain_block();
    @(negedge clk);
    sample_valid = 1'b0;
    while (pending_kth.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [swkth_pkg::CFG_IDX_W-1:0] idx,
                                input logic [swkth_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == swkth_pkg::REG_WINDOW_LENGTH) length_reg = val;
    else rank_reg = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      kth_value_stall = 1'b1;
      hold_left--;
    end else begin
      kth_value_stall = ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Compare every accepted word with the oldest expectation.
  always @(posedge clk) begin : check_word
    logic signed [31:0] want;
    if (rst_n && kth_value_valid && !kth_value_stall) begin
      if (pending_kth.size() == 0) begin
        $error("kth_value: no word expected, got %0d", kth_value);
        errors++;
      end else begin
        want = pending_kth.pop_front();
        if (kth_value !== want) begin
          $error("kth_value: expected %0d, got %0d", want, kth_value);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [swkth_pkg::CFG_W-1:0] len_pick;
    logic [swkth_pkg::CFG_W-1:0] rank_pick;

    // Directed table; starts from the reset setting of length 3, rank 2.
    add_sample_row(32'sh8000_0000, 1'b0, '0);
    add_sample_row(32'sh7fff_ffff, 1'b0, '0);
    add_sample_row(32'sd0, 1'b1, 32'sd0);
    add_sample_row(-32'sd1, 1'b1, 32'sd0);
    add_sample_row(-32'sd1, 1'b1, -32'sd1);
    // Rank zero acts as the minimum.
    add_config_row(swkth_pkg::REG_RANK, 5'd0);
    add_sample_row(32'sd5, 1'b1, -32'sd1);
    // Rank above the window length picks the maximum.
    add_config_row(swkth_pkg::REG_RANK, 5'd31);
    add_sample_row(32'sh8000_0000, 1'b1, 32'sd5);
    // Shrinking a filled window to one sample: each sample comes straight back.
    add_config_row(swkth_pkg::REG_WINDOW_LENGTH, 5'd1);
    add_sample_row(32'sh7fff_ffff, 1'b1, 32'sh7fff_ffff);
    // Length zero acts as one.
    add_config_row(swkth_pkg::REG_WINDOW_LENGTH, 5'd0);
    add_sample_row(32'sh5555_5555, 1'b1, 32'sh5555_5555);
    add_sample_row(32'shaaaa_aaaa, 1'b1, 32'shaaaa_aaaa);
    // Length above the maximum saturates; fill the widest window once.
    add_config_row(swkth_pkg::REG_WINDOW_LENGTH, 5'd31);
    add_config_row(swkth_pkg::REG_RANK, 5'd1);
    for (int i = 0; i < WINDOW_MAX; i++)
      add_sample_row((i % 2) ? -$signed(32'(i * 977)) : $signed(32'(i * 1234567)), 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CONFIG) begin
        drain_block();
        write_register(directed_rows[k].reg_index, directed_rows[k].reg_value);
      end else begin
        offer_sample(directed_rows[k].value, directed_rows[k].typed, directed_rows[k].want);
      end
    end

    // Random phases, each with its own setting and idling pattern.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_block();
      case ($urandom_range(0, 7))
        0: len_pick = 5'd0;
        1: len_pick = 5'd1;
        2: len_pick = 5'd16;
        3: len_pick = cfg_word_t'($urandom_range(17, 31));
        default: len_pick = cfg_word_t'($urandom_range(2, 6));
      endcase
      case ($urandom_range(0, 5))
        0: rank_pick = 5'd0;
        1: rank_pick = 5'd1;
        2: rank_pick = len_pick;
        3: rank_pick = 5'd16;
        4: rank_pick = cfg_word_t'($urandom_range(17, 31));
        default: rank_pick = cfg_word_t'($urandom_range(1, 4));
      endcase
      if (p == 1) begin
        len_pick = 5'd16;
        rank_pick = 5'd16;
      end
      write_register(swkth_pkg::REG_WINDOW_LENGTH, len_pick);
      write_register(swkth_pkg::REG_RANK, rank_pick);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 88; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 88; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      // One back-to-back phase runs against a long receiver hold-off.
      if (p == 4) begin
        @(posedge clk);
        hold_request = 1'b1;
      end
      repeat (PHASE_ITEMS) offer_sample(pick_sample(), 1'b0, '0);
    end

    drain_block();
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: sliding_window_kth_smallest.f
+incdir+hw/rtl
hw/rtl/swkth_pkg.sv
hw/rtl/swkth_cell.sv
hw/rtl/sliding_window_kth_smallest.sv
hw/rtl/swkth_checker.sv
bench/sliding_window_kth_smallest_test.sv
